### sv/twsm_pkg.sv
`default_nettype none

package twsm_pkg;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_WRITE  = 4'd2,
        PH_ACK    = 4'd3,
        PH_READY  = 4'd4,
        PH_CONV   = 4'd5,
        PH_READ   = 4'd6,
        PH_RACK   = 4'd7,
        PH_BUSRST = 4'd8
    } t_phase;

    // action codes of an input item
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_BUSRST = 2'd2;

    // sensor command bytes
    localparam logic [7:0] CMD_TEMP = 8'd3;
    localparam logic [7:0] CMD_HUM  = 8'd5;

    // start pattern, bit i is the level at step i
    localparam logic [7:0] START_CLK = 8'b0011_0110;
    localparam logic [7:0] START_DAT = 8'b0110_0011;

    // last start step, last bit of a byte, last byte, bus reset pulses
    localparam logic [2:0] START_LAST  = 3'd7;
    localparam logic [3:0] BIT_LAST    = 4'd7;
    localparam logic [1:0] BYTE_LAST   = 2'd2;
    localparam logic [3:0] RST_PULSES  = 4'd9;
    localparam logic [1:0] ERR_MAX     = 2'd2;

    // configuration register indexes
    localparam logic CFG_READY_TIMEOUT   = 1'b0;
    localparam logic CFG_CONVERSION_WAIT = 1'b1;

    // defaults after reset
    localparam logic [15:0] READY_TIMEOUT_RST   = 16'd65535;
    localparam logic [15:0] CONVERSION_WAIT_RST = 16'd500;

    // one result item
    typedef struct packed {
        logic [1:0]  error_count;
        logic [7:0]  checksum_byte;
        logic [15:0] result_value;
        logic        done_res;
        logic        busy_res;
        logic        data_enable;
        logic        data_out;
        logic        clock_out;
    } t_result;

endpackage

`default_nettype wire

### sv/twsm_core.sv
`default_nettype none

module twsm_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [1:0]       i_action,
    input  wire logic             i_mode,
    input  wire logic             i_data_in,
    input  wire logic [15:0]      i_ready_timeout,
    input  wire logic [15:0]      i_conversion_wait,
    output twsm_pkg::t_result     o_result
);
    import twsm_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_step,   n_step;
    logic [3:0]  r_bit,    n_bit;
    logic [1:0]  r_byte,   n_byte;
    logic [7:0]  r_shift,  n_shift;
    logic [7:0]  r_cmd,    n_cmd;
    logic [15:0] r_wait,   n_wait;
    logic [15:0] r_value,  n_value;
    logic [7:0]  r_check,  n_check;
    logic [1:0]  r_error,  n_error;
    logic        r_clk,    n_clk;
    logic        r_dat,    n_dat;
    logic        r_en,     n_en;
    logic        n_done;
    logic [16:0] wait_inc;
    logic [3:0]  bit_inc;

    assign wait_inc = {1'b0, r_wait} + 17'd1;

    // next state for one bus tick
    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_cmd   = r_cmd;
        n_wait  = r_wait;
        n_value = r_value;
        n_check = r_check;
        n_error = r_error;
        n_clk   = r_clk;
        n_dat   = r_dat;
        n_en    = r_en;
        n_done  = 1'b0;
        bit_inc = r_bit + 4'd1;

        // requests are taken only when idle
        if (r_phase == PH_IDLE && i_action == ACT_START) begin
            n_phase = PH_START;
            n_step  = '0;
            n_bit   = '0;
            n_byte  = '0;
            n_cmd   = i_mode ? CMD_HUM : CMD_TEMP;
            n_error = '0;
            n_wait  = '0;
        end else if (r_phase == PH_IDLE && i_action == ACT_BUSRST) begin
            n_phase = PH_BUSRST;
            n_step  = '0;
            n_bit   = '0;
        end
        bit_inc = n_bit + 4'd1;

        case (n_phase)
            PH_START: begin
                n_clk = START_CLK[n_step];
                n_dat = START_DAT[n_step];
                n_en  = 1'b1;
                if (n_step == START_LAST) begin
                    n_phase = PH_WRITE;
                    n_step  = '0;
                    n_bit   = '0;
                end else begin
                    n_step = n_step + 3'd1;
                end
            end
            PH_WRITE: begin
                n_en = 1'b1;
                if (n_step == 3'd0) begin
                    n_clk  = 1'b1;
                    n_dat  = n_cmd[3'd7 - n_bit[2:0]];
                    n_step = 3'd1;
                end else begin
                    n_clk  = 1'b0;
                    n_step = 3'd0;
                    if (n_bit >= BIT_LAST) n_phase = PH_ACK;
                    else                   n_bit   = bit_inc;
                end
            end
            PH_ACK: begin
                n_dat = 1'b1;
                n_en  = 1'b0;
                if (n_step == 3'd0) begin
                    n_clk  = 1'b1;
                    if (i_data_in && n_error < ERR_MAX) n_error = n_error + 2'd1;
                    n_step = 3'd1;
                end else begin
                    n_clk   = 1'b0;
                    n_step  = 3'd0;
                    n_phase = PH_READY;
                    n_wait  = '0;
                end
            end
            PH_READY: begin
                n_clk = 1'b0;
                n_dat = 1'b1;
                n_en  = 1'b0;
                if (!i_data_in) begin
                    n_phase = PH_CONV;
                    n_wait  = '0;
                end else if (wait_inc >= {1'b0, i_ready_timeout}) begin
                    if (n_error < ERR_MAX) n_error = n_error + 2'd1;
                    n_phase = PH_CONV;
                    n_wait  = '0;
                end else begin
                    n_wait = wait_inc[15:0];
                end
            end
            PH_CONV: begin
                n_clk = 1'b0;
                n_dat = 1'b1;
                n_en  = 1'b0;
                if (r_wait >= i_conversion_wait) begin
                    n_phase = PH_READ;
                    n_step  = '0;
                    n_bit   = '0;
                    n_byte  = '0;
                    n_shift = '0;
                end else begin
                    n_wait = wait_inc[15:0];
                end
            end
            PH_READ: begin
                n_dat = 1'b1;
                n_en  = 1'b0;
                if (n_step == 3'd0) begin
                    n_clk   = 1'b1;
                    n_shift = {n_shift[6:0], i_data_in};
                    n_step  = 3'd1;
                end else begin
                    n_clk  = 1'b0;
                    n_step = 3'd0;
                    if (n_bit >= BIT_LAST) n_phase = PH_RACK;
                    else                   n_bit   = bit_inc;
                end
            end
            PH_RACK: begin
                n_en = 1'b1;
                if (n_step == 3'd0) begin
                    // acknowledge low for the first two bytes
                    n_clk  = 1'b1;
                    n_dat  = (n_byte < BYTE_LAST) ? 1'b0 : 1'b1;
                    n_step = 3'd1;
                end else begin
                    n_clk  = 1'b0;
                    n_dat  = 1'b1;
                    n_step = 3'd0;
                    if (n_byte == 2'd0)      n_value = {n_shift, 8'h00};
                    else if (n_byte == 2'd1) n_value = {n_value[15:8], n_shift};
                    else                     n_check = n_shift;
                    if (n_byte >= BYTE_LAST) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                        n_byte  = '0;
                    end else begin
                        n_byte  = n_byte + 2'd1;
                        n_phase = PH_READ;
                        n_bit   = '0;
                        n_shift = '0;
                    end
                end
            end
            PH_BUSRST: begin
                n_dat = 1'b1;
                n_en  = 1'b1;
                if (n_step == 3'd0) begin
                    n_clk  = 1'b0;
                    n_step = 3'd1;
                end else if (n_step == 3'd1) begin
                    n_clk  = 1'b1;
                    n_step = 3'd2;
                end else begin
                    n_clk = 1'b0;
                    if (bit_inc >= RST_PULSES) begin
                        n_phase = PH_IDLE;
                        n_step  = '0;
                        n_bit   = '0;
                    end else begin
                        n_bit  = bit_inc;
                        n_step = 3'd1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // state registers, advanced once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= '0;
            r_cmd   <= '0;
            r_wait  <= '0;
            r_value <= '0;
            r_check <= '0;
            r_error <= '0;
            r_clk   <= 1'b0;
            r_dat   <= 1'b1;
            r_en    <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_cmd   <= n_cmd;
            r_wait  <= n_wait;
            r_value <= n_value;
            r_check <= n_check;
            r_error <= n_error;
            r_clk   <= n_clk;
            r_dat   <= n_dat;
            r_en    <= n_en;
        end
    end

    // result of this item, taken from the updated state
    always_comb begin
        o_result.clock_out     = n_clk;
        o_result.data_out      = n_dat;
        o_result.data_enable   = n_en;
        o_result.busy_res      = (n_phase != PH_IDLE);
        o_result.done_res      = n_done;
        o_result.result_value  = n_value;
        o_result.checksum_byte = n_check;
        o_result.error_count   = n_error;
    end

    // error count saturates at two
    a_error_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error != 2'd3)
        else $error("error count above two");

    // a released data line always reads back as high
    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_en |-> r_dat)
        else $error("data driven low while released");

    // a completed measurement leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_done) |=> (r_phase == PH_IDLE))
        else $error("done without return to idle");

    // byte counter never passes the checksum byte
    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte != 2'd3)
        else $error("byte counter out of range");

    // bus reset pulse count stays below nine
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit < RST_PULSES)
        else $error("bit counter out of range");

endmodule

`default_nettype wire

### sv/two_wire_sensor_measurement_master.sv
// The result item of an accepted input item is registered and valid in the cycle after it is taken.
// One item per cycle while the result side takes every result; the sequencer advances once per item and
// the output register is refilled in the same cycle it is emptied.
// Reset (i_rst_n low, synchronous): sequencer idle, clock low, data high and
// driven, counters, value and checksum cleared, output valid low, timeout 65535, wait 500.
`default_nettype none

module two_wire_sensor_measurement_master (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // action[1:0], mode[2], data_in[3], zeros
    // result item
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // clock_out[0], data_out[1], data_enable[2],
                                               // busy_res[3], done_res[4],
                                               // result_value[20:5], checksum_byte[28:21],
                                               // error_count[30:29], zero[31]
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata
);
    import twsm_pkg::*;

    logic        r_ready_timeout;
    logic [15:0] r_timeout;
    logic [15:0] r_conv_wait;
    logic        r_m_valid;
    t_result     r_m_data;
    t_result     core_result;
    logic        in_take;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout       <= READY_TIMEOUT_RST;
            r_conv_wait     <= CONVERSION_WAIT_RST;
            r_ready_timeout <= 1'b0;
        end else if (i_cfg_we) begin
            r_ready_timeout <= (i_cfg_idx == CFG_READY_TIMEOUT);
            if (i_cfg_idx == CFG_READY_TIMEOUT)   r_timeout   <= i_cfg_wdata;
            if (i_cfg_idx == CFG_CONVERSION_WAIT) r_conv_wait <= i_cfg_wdata;
        end
    end

    // bus sequencer
    twsm_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (in_take),
        .i_action          (i_s_axis_tdata[1:0]),
        .i_mode            (i_s_axis_tdata[2]),
        .i_data_in         (i_s_axis_tdata[3]),
        .i_ready_timeout   (r_timeout),
        .i_conversion_wait (r_conv_wait),
        .o_result          (core_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (in_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_m_data <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_m_data};

    // a held result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while result stalled");

    // every accepted item leaves a result behind
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_m_valid)
        else $error("accepted item produced no result");

    // last write flag follows the index
    a_cfg_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_READY_TIMEOUT) |=> r_ready_timeout)
        else $error("timeout write not tracked");

endmodule

`default_nettype wire
